// ===== rtl/cci_pkg.sv =====
// ----------------------------------------------------------------------------
// cci_pkg
// Shared constants, request/result types and controller-datapath interface
// of the calibration coefficient interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int EPOCH_W     = 33;
    localparam int COEFF_W     = 24;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = EPOCH_W + COEFF_W;
    localparam int DIV_CNT_W   = $clog2(COEFF_W);

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        M_CLAMP_LO = 2'd0,
        M_CLAMP_HI = 2'd1,
        M_SAME_DAY = 2'd2,
        M_INTERP   = 2'd3
    } t_method;

    typedef struct packed {
        t_req_type            req_type;
        logic [EPOCH_W-1:0]   entry_epoch;
        logic [COEFF_W-1:0]   entry_coeff;
        logic [EPOCH_W-1:0]   query_mjd;
    } t_req;

    typedef struct packed {
        logic [COEFF_W-1:0]   coeff_out;
        t_status              status;
        t_method              method;
    } t_res;

    typedef struct packed {
        logic [EPOCH_W-1:0]   epoch;
        logic [COEFF_W-1:0]   coeff;
    } t_point;

    typedef enum logic [2:0] {
        RD_NONE = 3'd0,
        RD_ZERO = 3'd1,
        RD_ONE  = 3'd2,
        RD_NEXT = 3'd3,
        RD_PREV = 3'd4,
        RD_LAST = 3'd5
    } t_rd_src;

    typedef enum logic [2:0] {
        RES_ZERO   = 3'd0,
        RES_FULL   = 3'd1,
        RES_EMPTY  = 3'd2,
        RES_POINT  = 3'd3,
        RES_INTERP = 3'd4
    } t_res_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_DAY,
        S_FIND,
        S_LO,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       count_clr;
        logic       wr_en;
        t_rd_src    rd_src;
        logic       hi_ld;
        logic       lo_ld;
        logic       mul_ld;
        logic       div_start;
        logic       res_ld;
        t_res_kind  res_kind;
        t_method    method;
        logic       out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic q_le;
        logic q_ge;
        logic q_lt;
        logic day_eq;
        logic idx_last;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/cci_div.sv =====
// ----------------------------------------------------------------------------
// cci_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// known to fit the coefficient width, so the upper numerator bits start out
// below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [cci_pkg::PROD_W-1:0]     i_num,
    input  wire logic [cci_pkg::EPOCH_W-1:0]    i_den,
    output logic                                o_done,
    output logic [cci_pkg::COEFF_W-1:0]         o_quot
);
    import cci_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [EPOCH_W-1:0]     r_rem;
    logic [EPOCH_W-1:0]     r_den;
    logic [COEFF_W-1:0]     r_sh;

    logic [EPOCH_W:0]       dividend;
    logic                   ge;
    logic [EPOCH_W:0]       diff;

    always_comb begin
        dividend = {r_rem, r_sh[COEFF_W-1]};
        ge       = dividend >= {1'b0, r_den};
        diff     = dividend - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(COEFF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[PROD_W-1:COEFF_W];
            r_sh  <= i_num[COEFF_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= diff[EPOCH_W-1:0];
            end else begin
                r_rem <= dividend[EPOCH_W-1:0];
            end
            r_sh <= {r_sh[COEFF_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

`default_nettype wire

// ===== rtl/cci_dp.sv =====
// ----------------------------------------------------------------------------
// cci_dp
// Datapath: point table memory, entry count, scan index, interpolation
// arithmetic with divider, result register and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cci_pkg::t_req      i_req,
    input  wire cci_pkg::t_dp_cmd   i_cmd,
    input  wire logic               i_out_ready,
    output cci_pkg::t_dp_sts        o_sts,
    output logic                    o_out_valid,
    output cci_pkg::t_res           o_res
);
    import cci_pkg::*;

    t_point                 mem [TABLE_DEPTH];

    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       n_idx;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       last_idx;
    logic [EPOCH_W-1:0]     r_q;
    t_point                 r_rdata;
    t_point                 r_hi;
    logic [EPOCH_W-1:0]     r_x;
    logic [EPOCH_W-1:0]     r_den;
    logic [COEFF_W-1:0]     r_mag;
    logic                   r_neg;
    logic [COEFF_W-1:0]     r_cb;
    logic [PROD_W-1:0]      r_prod;
    t_res                   r_res;
    t_res                   n_res;
    t_res                   r_out;
    logic                   r_out_valid;

    logic                   div_done;
    logic [COEFF_W-1:0]     quot;
    logic [COEFF_W-1:0]     interp;

    assign last_idx = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        rd_addr = r_idx;
        n_idx   = r_idx;
        unique case (i_cmd.rd_src)
            RD_ZERO: begin
                rd_addr = '0;
                n_idx   = '0;
            end
            RD_ONE: begin
                rd_addr = IDX_W'(1);
                n_idx   = IDX_W'(1);
            end
            RD_NEXT: begin
                rd_addr = r_idx + IDX_W'(1);
                n_idx   = r_idx + IDX_W'(1);
            end
            RD_PREV: begin
                rd_addr = r_idx - IDX_W'(1);
            end
            RD_LAST: begin
                rd_addr = last_idx;
            end
            default: begin
            end
        endcase
    end

    // point table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_count[IDX_W-1:0]] <= '{epoch: i_req.entry_epoch, coeff: i_req.entry_coeff};
        end
        if (i_cmd.rd_src != RD_NONE) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_clr) begin
            r_count <= '0;
        end else if (i_cmd.wr_en) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.accept) begin
            r_q <= i_req.query_mjd;
        end
        if (i_cmd.hi_ld) begin
            r_hi <= r_rdata;
        end
        if (i_cmd.lo_ld) begin
            r_x   <= r_q - r_rdata.epoch;
            r_den <= r_hi.epoch - r_rdata.epoch;
            r_cb  <= r_rdata.coeff;
            r_neg <= r_hi.coeff < r_rdata.coeff;
            if (r_hi.coeff < r_rdata.coeff) begin
                r_mag <= r_rdata.coeff - r_hi.coeff;
            end else begin
                r_mag <= r_hi.coeff - r_rdata.coeff;
            end
        end
        if (i_cmd.mul_ld) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(r_x);
        end
    end

    cci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // result lies between the two neighbor coefficients
    assign interp = r_neg ? (r_cb - quot) : (r_cb + quot);

    always_comb begin
        n_res = '{coeff_out: '0, status: ST_DONE, method: M_CLAMP_LO};
        unique case (i_cmd.res_kind)
            RES_FULL:   n_res.status = ST_FULL;
            RES_EMPTY:  n_res.status = ST_EMPTY;
            RES_POINT: begin
                n_res.coeff_out = r_rdata.coeff;
                n_res.method    = i_cmd.method;
            end
            RES_INTERP: begin
                n_res.coeff_out = interp;
                n_res.method    = M_INTERP;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_res <= n_res;
        end
        if (i_cmd.out_ld) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.count_zero = r_count == '0;
        o_sts.count_full = r_count == CNT_W'(TABLE_DEPTH);
        o_sts.q_le       = r_q <= r_rdata.epoch;
        o_sts.q_ge       = r_q >= r_rdata.epoch;
        o_sts.q_lt       = r_q < r_rdata.epoch;
        o_sts.day_eq     = r_q[EPOCH_W-1:FRAC_W] == r_rdata.epoch[EPOCH_W-1:FRAC_W];
        o_sts.idx_last   = r_idx == last_idx;
        o_sts.div_done   = div_done;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ===== rtl/cci_ctrl.sv =====
// ----------------------------------------------------------------------------
// cci_ctrl
// Controller: decodes each request and sequences the table scans, the
// interpolation arithmetic and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire cci_pkg::t_req_type     i_req_type,
    input  wire cci_pkg::t_dp_sts       i_sts,
    output logic                        o_in_ready,
    output cci_pkg::t_dp_cmd            o_cmd
);
    import cci_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.res_ld = 1'b1;
                    n_state      = S_RESULT;
                    unique case (i_req_type)
                        REQ_CLEAR: begin
                            o_cmd.count_clr = 1'b1;
                        end
                        REQ_APPEND: begin
                            if (i_sts.count_full) begin
                                o_cmd.res_kind = RES_FULL;
                            end else begin
                                o_cmd.wr_en = 1'b1;
                            end
                        end
                        REQ_QUERY: begin
                            if (i_sts.count_zero) begin
                                o_cmd.res_kind = RES_EMPTY;
                            end else begin
                                o_cmd.res_ld = 1'b0;
                                o_cmd.rd_src = RD_ZERO;
                                n_state      = S_FIRST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIRST: begin
                if (i_sts.q_le) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_kind = RES_POINT;
                    o_cmd.method   = M_CLAMP_LO;
                    n_state        = S_RESULT;
                end else begin
                    o_cmd.rd_src = RD_LAST;
                    n_state      = S_LAST;
                end
            end
            S_LAST: begin
                if (i_sts.q_ge) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_kind = RES_POINT;
                    o_cmd.method   = M_CLAMP_HI;
                    n_state        = S_RESULT;
                end else begin
                    o_cmd.rd_src = RD_ZERO;
                    n_state      = S_DAY;
                end
            end
            S_DAY: begin
                if (i_sts.day_eq) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_kind = RES_POINT;
                    o_cmd.method   = M_SAME_DAY;
                    n_state        = S_RESULT;
                end else if (i_sts.idx_last) begin
                    o_cmd.rd_src = RD_ONE;
                    n_state      = S_FIND;
                end else begin
                    o_cmd.rd_src = RD_NEXT;
                end
            end
            S_FIND: begin
                if (i_sts.q_lt) begin
                    o_cmd.hi_ld  = 1'b1;
                    o_cmd.rd_src = RD_PREV;
                    n_state      = S_LO;
                end else begin
                    o_cmd.rd_src = RD_NEXT;
                end
            end
            S_LO: begin
                o_cmd.lo_ld = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_ld = 1'b1;
                n_state      = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_kind = RES_INTERP;
                    n_state        = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/calibration_coeff_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// calibration_coeff_interpolator_core
// Calibration point table with clamped, same-day and linear interpolation
// lookup of a coefficient by epoch.
// ----------------------------------------------------------------------------
// Requests are taken one at a time; each gives exactly one result, held in
// an output register so the next request can be taken while it waits.
// Clear, append, unused codes and queries on an empty table go straight to
// the result. A query first checks the clamp at the first point, then at
// the last point, then scans from index 0 for a same-day hit; an
// interpolated query scans again from index 1 for its upper neighbor. The
// table memory has one read port, so both scans visit one point per cycle,
// and the divider produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module calibration_coeff_interpolator_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire cci_pkg::t_req      i_req,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cci_pkg::t_res           o_res
);
    import cci_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    cci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_in_ready (o_ready),
        .o_cmd      (cmd)
    );

    cci_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_out_ready (i_ready),
        .o_sts       (sts),
        .o_out_valid (o_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
